### rtl/brs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the background RSSI scan core.
// ---------------------------------------------------------------------------
package brs_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int LEVEL_W       = 8;
	localparam int PCT_W         = 7;
	localparam int COUNT_W       = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// average in Q8.FRACTION_BITS
	localparam int AVG_W = LEVEL_W + FRACTION_BITS;
	// blend numerator avg*p + s*(100-p) stays below 100 * 2^AVG_W
	localparam int NUM_W = AVG_W + PCT_W;

	// floor(n/100) = (n * RECIP) >> RECIP_SH for every n below 2^NUM_W
	localparam int          RECIP_SH = NUM_W + PCT_W;
	localparam logic [63:0] RECIP    = ((64'd1 << RECIP_SH) + 64'd99) / 64'd100;
	localparam int          RECIP_W  = $clog2(RECIP + 64'd1);

	// shared multiplier operand widths
	localparam int MUL_A_W = NUM_W;
	localparam int MUL_B_W = RECIP_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// duty: busy*100 / steps, quotient never above 100
	localparam int DUTY_NUM_W = COUNT_W + PCT_W;
	localparam int QBIT_W     = $clog2(PCT_W);

	localparam logic [PCT_W-1:0] PERCENT_FULL = PCT_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_LEVEL     = 3'd0,
		REG_BUSY_THRESHOLD    = 3'd1,
		REG_NOISE_THRESHOLD   = 3'd2,
		REG_SMOOTHING_PERCENT = 3'd3,
		REG_SAMPLE_COUNT      = 3'd4
	} brs_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               abort;
	} brs_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] background_level;
		logic [PCT_W-1:0]   duty_percent;
	} brs_out_t;

endpackage
`default_nettype wire

### rtl/brs_mult.sv
`default_nettype none
// ---------------------------------------------------------------------------
// brs_mult
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module brs_mult (
	input  wire logic                        clk,
	input  wire logic [brs_pkg::MUL_A_W-1:0] a,
	input  wire logic [brs_pkg::MUL_B_W-1:0] b,
	output logic      [brs_pkg::PROD_W-1:0]  prod
);

	always_ff @(posedge clk) begin
		prod <= brs_pkg::PROD_W'(a) * brs_pkg::PROD_W'(b);
	end

endmodule
`default_nettype wire

### rtl/background_rssi_scan_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// background_rssi_scan_core
// Channel occupancy scan: running averages of RSSI words and a busy duty.
// ---------------------------------------------------------------------------
// Usage:
//   sample channel  - one RSSI word per handshake (level, abort). The first
//                     non-abort word taken while no scan runs starts a scan.
//   result channel  - one word per finished scan: background level (noise
//                     average if one was seeded, else main average) and the
//                     busy duty in percent.
//   cfg channel     - register index + data, always ready; write only while
//                     the core is idle between scans.
// Timing: every sample is accepted, then runs the main blend (multiply old,
//   multiply new, sum, reciprocal, write), and the blend again when the noise
//   average is blended as well. Both blends and the divide by 100 run
//   through one registered multiplier. A seeding word with no blend needs
//   only the accept. The word that ends a scan adds busy*100, 7 restoring
//   divide steps and the result load before the result shows up.
// Stall: a finished result sits in the output register; the next sample is
//   accepted meanwhile. A scan that finishes while the old result is still
//   unread waits in its load state until result_ready frees the register.
// Reset: arst_n clears the scan state and loads the register defaults
//   (smoothing 90 percent, 200 samples per scan). No result pending.
// ---------------------------------------------------------------------------
module background_rssi_scan_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           sample_valid,
	output logic                                sample_ready,
	input  wire brs_pkg::brs_in_t               sample,

	output logic                                result_valid,
	input  wire logic                           result_ready,
	output brs_pkg::brs_out_t                   result,

	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [brs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int F = brs_pkg::FRACTION_BITS;

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_B_MUL_OLD = 10'b00_0000_0010,  // avg * p
		S_B_MUL_NEW = 10'b00_0000_0100,  // level * (100 - p)
		S_B_SUM     = 10'b00_0000_1000,  // numerator add
		S_B_RECIP   = 10'b00_0001_0000,  // numerator * 1/100
		S_B_WRITE   = 10'b00_0010_0000,  // store blended average
		S_D_MUL     = 10'b00_0100_0000,  // busy * 100
		S_D_LOAD    = 10'b00_1000_0000,
		S_D_DIV     = 10'b01_0000_0000,  // one quotient bit per cycle
		S_OUT       = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [brs_pkg::LEVEL_W-1:0] init_level_q;
	logic [brs_pkg::LEVEL_W-1:0] busy_th_q;
	logic [brs_pkg::LEVEL_W-1:0] noise_th_q;
	logic [brs_pkg::PCT_W-1:0]   smooth_q;
	logic [brs_pkg::COUNT_W-1:0] sample_cnt_q;

	// scan state
	logic                        scan_active_q;
	logic [brs_pkg::AVG_W-1:0]   main_avg_q;
	logic [brs_pkg::AVG_W-1:0]   noise_avg_q;
	logic                        noise_started_q;
	logic [brs_pkg::COUNT_W-1:0] steps_q;
	logic [brs_pkg::COUNT_W-1:0] busy_q;

	// sequencer working registers
	logic                           blend_noise_q;
	logic                           need_noise_q;
	logic [brs_pkg::LEVEL_W-1:0]    lvl_q;
	logic [brs_pkg::NUM_W-1:0]      num_q;
	logic [brs_pkg::DUTY_NUM_W-1:0] rem_q;
	logic [brs_pkg::PCT_W-1:0]      quo_q;
	logic [brs_pkg::QBIT_W-1:0]     bit_q;
	logic                           result_valid_q;
	brs_pkg::brs_out_t              result_q;

	// shared multiplier
	logic [brs_pkg::MUL_A_W-1:0] mul_a;
	logic [brs_pkg::MUL_B_W-1:0] mul_b;
	logic [brs_pkg::PROD_W-1:0]  prod;

	brs_mult u_mult (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// smoothing above 100 saturates, holding the average
	logic [brs_pkg::PCT_W-1:0] p_sat;
	assign p_sat = (smooth_q > brs_pkg::PERCENT_FULL) ? brs_pkg::PERCENT_FULL : smooth_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_B_MUL_OLD: begin
				mul_a = brs_pkg::MUL_A_W'(blend_noise_q ? noise_avg_q : main_avg_q);
				mul_b = brs_pkg::MUL_B_W'(p_sat);
			end
			S_B_MUL_NEW: begin
				mul_a = brs_pkg::MUL_A_W'(lvl_q);
				mul_b = brs_pkg::MUL_B_W'(brs_pkg::PERCENT_FULL - p_sat);
			end
			S_B_RECIP: begin
				mul_a = brs_pkg::MUL_A_W'(num_q);
				mul_b = brs_pkg::MUL_B_W'(brs_pkg::RECIP);
			end
			S_D_MUL: begin
				mul_a = brs_pkg::MUL_A_W'(busy_q);
				mul_b = brs_pkg::MUL_B_W'(brs_pkg::PERCENT_FULL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// handshakes
	logic sample_take;
	logic out_load;
	assign sample_ready = (state_q == S_IDLE);
	assign sample_take  = sample_valid && sample_ready;
	assign out_load     = (state_q == S_OUT) && (!result_valid_q || result_ready);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// values seen by a word that may be starting a scan
	logic                        starting;
	logic                        tested;
	logic                        started_eff;
	logic [brs_pkg::COUNT_W-1:0] steps_base;
	logic [brs_pkg::COUNT_W-1:0] busy_base;
	logic [brs_pkg::COUNT_W-1:0] steps_next;
	logic [brs_pkg::COUNT_W-1:0] busy_next;

	assign starting    = !scan_active_q;
	assign tested      = scan_active_q || (init_level_q != '0);
	assign started_eff = scan_active_q && noise_started_q;
	assign steps_base  = scan_active_q ? steps_q : '0;
	assign busy_base   = scan_active_q ? busy_q : '0;

	always_comb begin
		if (!tested) begin
			steps_next = brs_pkg::COUNT_W'(1);
		end else if (steps_base != '1) begin
			steps_next = steps_base + brs_pkg::COUNT_W'(1);
		end else begin
			steps_next = steps_base;
		end
		busy_next = busy_base;
		if (tested && (sample.level < busy_th_q)) begin
			busy_next = busy_base + brs_pkg::COUNT_W'(1);
		end
	end

	// floor(num/100): top bits of num * RECIP
	logic [brs_pkg::AVG_W-1:0]      blend_val;
	logic [brs_pkg::DUTY_NUM_W-1:0] div_sh;
	assign blend_val = prod[brs_pkg::RECIP_SH +: brs_pkg::AVG_W];
	assign div_sh    = brs_pkg::DUTY_NUM_W'(steps_q) << bit_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_level_q <= '0;
			busy_th_q    <= '0;
			noise_th_q   <= '0;
			smooth_q     <= brs_pkg::PCT_W'(90);
			sample_cnt_q <= brs_pkg::COUNT_W'(200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				brs_pkg::REG_INITIAL_LEVEL:     init_level_q <= cfg_data[brs_pkg::LEVEL_W-1:0];
				brs_pkg::REG_BUSY_THRESHOLD:    busy_th_q    <= cfg_data[brs_pkg::LEVEL_W-1:0];
				brs_pkg::REG_NOISE_THRESHOLD:   noise_th_q   <= cfg_data[brs_pkg::LEVEL_W-1:0];
				brs_pkg::REG_SMOOTHING_PERCENT: smooth_q     <= cfg_data[brs_pkg::PCT_W-1:0];
				brs_pkg::REG_SAMPLE_COUNT:      sample_cnt_q <= cfg_data[brs_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			scan_active_q   <= 1'b0;
			main_avg_q      <= '0;
			noise_avg_q     <= '0;
			noise_started_q <= 1'b0;
			steps_q         <= '0;
			busy_q          <= '0;
			blend_noise_q   <= 1'b0;
			need_noise_q    <= 1'b0;
			result_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample_take) begin
						if (sample.abort) begin
							// abort while idle is dropped
							if (scan_active_q) begin
								state_q <= S_D_MUL;
							end
						end else begin
							scan_active_q <= 1'b1;
							steps_q       <= steps_next;
							busy_q        <= busy_next;
							blend_noise_q <= 1'b0;
							need_noise_q  <= tested && started_eff &&
								(sample.level < noise_th_q);
							if (starting) begin
								main_avg_q <= (init_level_q != '0)
									? {init_level_q, {F{1'b0}}}
									: {sample.level, {F{1'b0}}};
							end
							// first nonzero quiet word that is tested seeds the noise average
							if (tested && !started_eff && (sample.level < noise_th_q) &&
								(sample.level != '0)) begin
								noise_avg_q     <= {sample.level, {F{1'b0}}};
								noise_started_q <= 1'b1;
							end else if (starting) begin
								noise_avg_q     <= '0;
								noise_started_q <= 1'b0;
							end
							if (tested) begin
								state_q <= S_B_MUL_OLD;
							end else if (steps_next >= sample_cnt_q) begin
								state_q <= S_D_MUL;
							end
						end
					end
				end
				S_B_MUL_OLD: state_q <= S_B_MUL_NEW;
				S_B_MUL_NEW: state_q <= S_B_SUM;
				S_B_SUM:     state_q <= S_B_RECIP;
				S_B_RECIP:   state_q <= S_B_WRITE;
				S_B_WRITE: begin
					if (blend_noise_q) begin
						noise_avg_q <= blend_val;
					end else begin
						main_avg_q <= blend_val;
					end
					if (!blend_noise_q && need_noise_q) begin
						blend_noise_q <= 1'b1;
						state_q       <= S_B_MUL_OLD;
					end else if (steps_q >= sample_cnt_q) begin
						state_q <= S_D_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_D_MUL: state_q <= S_D_LOAD;
				S_D_LOAD: begin
					state_q <= (steps_q == '0) ? S_OUT : S_D_DIV;
				end
				S_D_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						scan_active_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (sample_take) begin
			lvl_q <= sample.level;
		end
		unique case (state_q)
			S_B_MUL_NEW: num_q <= prod[brs_pkg::NUM_W-1:0];
			S_B_SUM:     num_q <= num_q + (prod[brs_pkg::NUM_W-1:0] << F);
			S_D_LOAD: begin
				rem_q <= prod[brs_pkg::DUTY_NUM_W-1:0];
				quo_q <= '0;
				bit_q <= brs_pkg::QBIT_W'(brs_pkg::PCT_W - 1);
			end
			S_D_DIV: begin
				if (rem_q >= div_sh) begin
					rem_q        <= rem_q - div_sh;
					quo_q[bit_q] <= 1'b1;
				end
				if (bit_q != '0) begin
					bit_q <= bit_q - brs_pkg::QBIT_W'(1);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			result_q.background_level <= noise_started_q
				? noise_avg_q[F +: brs_pkg::LEVEL_W]
				: main_avg_q[F +: brs_pkg::LEVEL_W];
			result_q.duty_percent     <= quo_q;
		end
	end

	// assertions
	logic [brs_pkg::DUTY_NUM_W:0] div_bound;
	assign div_bound = (brs_pkg::DUTY_NUM_W + 1)'(steps_q) << (bit_q + brs_pkg::QBIT_W'(1));

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_blend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_MUL_OLD || state_q == S_B_WRITE) |-> scan_active_q)
		else $error("blend running outside a scan");

	a_noise_blend_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_MUL_OLD && blend_noise_q) |-> noise_started_q)
		else $error("noise blend before noise seed");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D_DIV) |-> ((brs_pkg::DUTY_NUM_W + 1)'(rem_q) < div_bound))
		else $error("duty remainder out of range");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.duty_percent <= brs_pkg::PERCENT_FULL))
		else $error("duty above 100 percent");

endmodule
`default_nettype wire
